### src/hcbd_pkg.sv
// Shared types, character codes and helpers for the chunked body decoder.
// No dependencies; imported by hcbd_step and http_chunked_body_decoder_core.
package hcbd_pkg;

  localparam int unsigned SizeBitsDef  = 32;
  localparam int unsigned CountBitsDef = 32;
  localparam int unsigned CountOutBits = 32;

  localparam logic [7:0] ChrCr    = 8'h0d;
  localparam logic [7:0] ChrLf    = 8'h0a;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrTab   = 8'h09;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_SIZE_CR = 3'd1,
    PH_DATA    = 3'd2,
    PH_DATA_CR = 3'd3,
    PH_DATA_LF = 3'd4,
    PH_END_CR  = 3'd5,
    PH_END_LF  = 3'd6,
    PH_HALT    = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  // Phase and size-line flags moved between the state registers and the step logic
  typedef struct packed {
    phase_e phase;
    logic   digit_seen;
    logic   digits_ended;
  } ctrl_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= "0" && c <= "9") begin
      h.val = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      h.val = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      h.val = 4'(c - "A" + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

### src/http_chunked_body_decoder_core.sv
// Top level of the HTTP chunked body decoder: input register, state, result register.
// Depends on hcbd_pkg and hcbd_step.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   in      | in_valid_i / in_stall_o | in_byte_i, body_start_i
//   out     | out_valid_o / out_stall_i | out_byte_o, status_o, consumed_count_o
//
// One byte per cycle sustained while the output does not stall; a byte passes through
// the input register and then the result register around hcbd_step, which presents
// its result.
// Bytes that produce no result (size lines, CR LF) are absorbed with no gap.
// Reset returns the decoder to the start of a size line with counters cleared.
// A stalled result holds the input register; the input stalls only when that
// register is full and cannot move on.
module http_chunked_body_decoder_core
  import hcbd_pkg::*;
#(
  parameter int unsigned SIZE_BITS  = SizeBitsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              in_byte_i,
  input  logic                    body_start_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              out_byte_o,
  output logic [1:0]              status_o,
  output logic [CountOutBits-1:0] consumed_count_o
);

  logic                    in_v_q;
  logic [7:0]              in_byte_q;
  logic                    in_start_q;

  ctrl_t                   ctrl_q, ctrl_d;
  logic [SIZE_BITS-1:0]    chunk_q, chunk_d;
  logic [COUNT_BITS-1:0]   count_q, count_d;

  logic                    res_valid;
  logic [7:0]              res_byte;
  status_e                 res_status;
  logic [CountOutBits-1:0] res_count;

  logic                    out_v_q;
  logic [7:0]              out_byte_q;
  status_e                 out_status_q;
  logic [CountOutBits-1:0] out_count_q;

  logic out_free;
  logic advance;
  logic in_take;

  assign out_free   = !out_v_q || !out_stall_i;
  assign advance    = in_v_q && out_free;
  assign in_stall_o = in_v_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  hcbd_step #(
    .SIZE_BITS (SIZE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .byte_i      (in_byte_q),
    .body_start_i(in_start_q),
    .ctrl_i      (ctrl_q),
    .chunk_i     (chunk_q),
    .count_i     (count_q),
    .ctrl_o      (ctrl_d),
    .chunk_o     (chunk_d),
    .count_o     (count_d),
    .res_valid_o (res_valid),
    .res_byte_o  (res_byte),
    .res_status_o(res_status),
    .res_count_o (res_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      ctrl_q  <= '{phase: PH_SIZE, digit_seen: 1'b0, digits_ended: 1'b0};
      chunk_q <= '0;
      count_q <= '0;
    end else begin
      if (in_take) begin
        in_v_q <= 1'b1;
      end else if (advance) begin
        in_v_q <= 1'b0;
      end
      if (advance) begin
        ctrl_q  <= ctrl_d;
        chunk_q <= chunk_d;
        count_q <= count_d;
      end
      if (out_free) begin
        out_v_q <= advance && res_valid;
      end
    end
  end

  // payload registers: load on transfer only
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= in_byte_i;
      in_start_q <= body_start_i;
    end
    if (advance && res_valid) begin
      out_byte_q   <= res_byte;
      out_status_q <= res_status;
      out_count_q  <= res_count;
    end
  end

  assign out_valid_o      = out_v_q;
  assign out_byte_o       = out_byte_q;
  assign status_o         = out_status_q;
  assign consumed_count_o = out_count_q;

endmodule

### src/hcbd_step.sv
// Per-byte next-state and result logic of the chunked body decoder.
// Depends on hcbd_pkg; purely combinational, registered by the top level.
module hcbd_step
  import hcbd_pkg::*;
#(
  parameter int unsigned SIZE_BITS  = SizeBitsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic [7:0]              byte_i,
  input  logic                    body_start_i,
  input  ctrl_t                   ctrl_i,
  input  logic [SIZE_BITS-1:0]    chunk_i,
  input  logic [COUNT_BITS-1:0]   count_i,
  output ctrl_t                   ctrl_o,
  output logic [SIZE_BITS-1:0]    chunk_o,
  output logic [COUNT_BITS-1:0]   count_o,
  output logic                    res_valid_o,
  output logic [7:0]              res_byte_o,
  output status_e                 res_status_o,
  output logic [CountOutBits-1:0] res_count_o
);

  ctrl_t                 ctrl;
  logic [SIZE_BITS-1:0]  chunk;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_inc;
  logic [SIZE_BITS-1:0]  chunk_dec;
  logic [63:0]           count_wide;
  hex_t                  hex;
  logic                  blank;

  assign hex   = hex_decode(byte_i);
  assign blank = (byte_i == ChrSpace) || (byte_i == ChrTab);

  always_comb begin
    // body start clears everything before this byte is looked at
    if (body_start_i) begin
      ctrl  = '{phase: PH_SIZE, digit_seen: 1'b0, digits_ended: 1'b0};
      chunk = '0;
      count = '0;
    end else begin
      ctrl  = ctrl_i;
      chunk = chunk_i;
      count = count_i;
    end
  end

  assign count_inc  = (&count) ? count : count + COUNT_BITS'(1);
  assign chunk_dec  = chunk - SIZE_BITS'(1);
  assign count_wide = 64'(count_inc);

  always_comb begin
    ctrl_o       = ctrl;
    chunk_o      = chunk;
    count_o      = count;
    res_valid_o  = 1'b0;
    res_byte_o   = 8'd0;
    res_status_o = ST_DATA;
    res_count_o  = '0;

    if (ctrl.phase != PH_HALT) begin
      count_o = count_inc;
    end

    unique case (ctrl.phase)
      PH_SIZE: begin
        if (byte_i == ChrCr) begin
          ctrl_o.phase = PH_SIZE_CR;
        end else if (!ctrl.digits_ended) begin
          if (hex.ok) begin
            if (chunk[SIZE_BITS-1 -: 4] != 4'd0) begin
              ctrl_o.phase = PH_HALT;
              res_valid_o  = 1'b1;
              res_status_o = ST_BAD;
            end else begin
              chunk_o           = {chunk[SIZE_BITS-5:0], hex.val};
              ctrl_o.digit_seen = 1'b1;
            end
          end else if (!(blank && !ctrl.digit_seen)) begin
            ctrl_o.digits_ended = 1'b1;
          end
        end
      end
      PH_SIZE_CR: begin
        if (byte_i == ChrLf) begin
          if (!ctrl.digit_seen) begin
            ctrl_o.phase = PH_HALT;
            res_valid_o  = 1'b1;
            res_status_o = ST_BAD;
          end else begin
            ctrl_o.phase = (chunk == '0) ? PH_END_CR : PH_DATA;
          end
        end else begin
          // lone CR: treat as an ordinary line character, which ends the digit run
          ctrl_o.digits_ended = 1'b1;
          if (byte_i != ChrCr) begin
            ctrl_o.phase = PH_SIZE;
          end
        end
      end
      PH_DATA: begin
        chunk_o = chunk_dec;
        if (chunk_dec == '0) begin
          ctrl_o.phase = PH_DATA_CR;
        end
        res_valid_o  = 1'b1;
        res_byte_o   = byte_i;
        res_status_o = ST_DATA;
      end
      PH_DATA_CR, PH_END_CR: begin
        if (byte_i != ChrCr) begin
          ctrl_o.phase = PH_HALT;
          res_valid_o  = 1'b1;
          res_status_o = ST_BAD;
        end else begin
          ctrl_o.phase = (ctrl.phase == PH_DATA_CR) ? PH_DATA_LF : PH_END_LF;
        end
      end
      PH_DATA_LF: begin
        if (byte_i != ChrLf) begin
          ctrl_o.phase = PH_HALT;
          res_valid_o  = 1'b1;
          res_status_o = ST_BAD;
        end else begin
          ctrl_o  = '{phase: PH_SIZE, digit_seen: 1'b0, digits_ended: 1'b0};
          chunk_o = '0;
        end
      end
      PH_END_LF: begin
        ctrl_o.phase = PH_HALT;
        res_valid_o  = 1'b1;
        if (byte_i != ChrLf) begin
          res_status_o = ST_BAD;
        end else begin
          res_status_o = ST_DONE;
          res_count_o  = count_wide[CountOutBits-1:0];
        end
      end
      PH_HALT: begin
        // hold until the next body start
      end
    endcase
  end

endmodule

### tb/sv/hcbd_tb_pkg.sv
// Scoreboard for the chunked body decoder testbench: a byte-level decode predictor
// and the queue of results awaited from the block. Depends on hcbd_pkg.
package hcbd_tb_pkg;
  import hcbd_pkg::*;

  typedef struct packed {
    logic [7:0]              data;
    status_e                 status;
    logic [CountOutBits-1:0] count;
  } decode_result_t;

  class chunk_decode_scoreboard;
    phase_e                 ph;
    logic [SizeBitsDef-1:0] size_left;
    bit                     digit_seen;
    bit                     digits_ended;
    logic [CountBitsDef-1:0] consumed;
    decode_result_t         awaited[$];

    int errors;
    int live_bytes;
    int bodies;
    int data_seen;
    int done_seen;
    int bad_seen;

    function new();
      clear_body();
    endfunction

    function void clear_body();
      ph           = PH_SIZE;
      size_left    = '0;
      digit_seen   = 1'b0;
      digits_ended = 1'b0;
      consumed     = '0;
    endfunction

    function int awaiting();
      return awaited.size();
    endfunction

    function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
        v = c[3:0];
        return 1'b1;
      end
      if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
        v = 4'(c[2:0] + 3'd1) + 4'd8;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // One size-line character; returns 1 when the size would overflow.
    function bit size_line_char(input logic [7:0] c);
      logic [3:0] v;
      if (digits_ended) return 1'b0;
      if (hex_nibble(c, v)) begin
        if (size_left[SizeBitsDef-1 -: 4] != 4'd0) return 1'b1;
        size_left  = {size_left[SizeBitsDef-5:0], v};
        digit_seen = 1'b1;
        return 1'b0;
      end
      if ((c == ChrSpace || c == ChrTab) && !digit_seen) return 1'b0;
      digits_ended = 1'b1;
      return 1'b0;
    endfunction

    function void queue_result(input logic [7:0] d, input status_e st,
                               input logic [CountOutBits-1:0] cnt);
      decode_result_t r;
      r.data   = d;
      r.status = st;
      r.count  = cnt;
      awaited.push_back(r);
    endfunction

    function void malformed();
      ph = PH_HALT;
      queue_result(8'h00, ST_BAD, '0);
    endfunction

    // Advance the predicted decoder by one accepted byte.
    function void decode_byte(input logic [7:0] c, input logic start);
      if (start) begin
        clear_body();
        bodies++;
      end
      if (ph == PH_HALT) return;
      live_bytes++;
      if (consumed != '1) consumed++;
      case (ph)
        PH_SIZE: begin
          if (c == ChrCr) ph = PH_SIZE_CR;
          else if (size_line_char(c)) malformed();
        end
        PH_SIZE_CR: begin
          if (c == ChrLf) begin
            if (!digit_seen) malformed();
            else ph = (size_left == '0) ? PH_END_CR : PH_DATA;
          end else begin
            // a lone CR is just another line character
            digits_ended = 1'b1;
            if (c != ChrCr) begin
              ph = PH_SIZE;
              if (size_line_char(c)) malformed();
            end
          end
        end
        PH_DATA: begin
          size_left--;
          if (size_left == '0) ph = PH_DATA_CR;
          queue_result(c, ST_DATA, '0);
        end
        PH_DATA_CR: begin
          if (c != ChrCr) malformed();
          else ph = PH_DATA_LF;
        end
        PH_DATA_LF: begin
          if (c != ChrLf) malformed();
          else begin
            ph           = PH_SIZE;
            size_left    = '0;
            digit_seen   = 1'b0;
            digits_ended = 1'b0;
          end
        end
        PH_END_CR: begin
          if (c != ChrCr) malformed();
          else ph = PH_END_LF;
        end
        PH_END_LF: begin
          if (c != ChrLf) malformed();
          else begin
            ph = PH_HALT;
            queue_result(8'h00, ST_DONE, CountOutBits'(consumed));
          end
        end
        default: ph = PH_HALT;
      endcase
    endfunction

    // Compare one transfer from the block against the oldest awaited result.
    function void compare_output(input logic [7:0] d, input logic [1:0] st,
                                 input logic [CountOutBits-1:0] cnt, input longint t_ns);
      decode_result_t r;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0d ns: unexpected result byte=%h status=%0d count=%0d", t_ns, d, st, cnt);
        return;
      end
      r = awaited.pop_front();
      case (r.status)
        ST_DATA: data_seen++;
        ST_DONE: done_seen++;
        default: bad_seen++;
      endcase
      if (st !== r.status) begin
        errors++;
        $display("%0d ns: status expected %0d, got %0d", t_ns, r.status, st);
      end
      if (d !== r.data) begin
        errors++;
        $display("%0d ns: out_byte expected %h, got %h", t_ns, r.data, d);
      end
      if (cnt !== r.count) begin
        errors++;
        $display("%0d ns: consumed_count expected %0d, got %0d", t_ns, r.count, cnt);
      end
    endfunction
  endclass

endpackage

### tb/sv/tb_http_chunked_body_decoder_core.sv
// Self-checking testbench for http_chunked_body_decoder_core: directed and random
// chunked bodies, random idling on both sides. Depends on hcbd_pkg and hcbd_tb_pkg.
module tb_http_chunked_body_decoder_core;
  import hcbd_pkg::*;
  import hcbd_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_stall_o;
  logic [7:0]              in_byte_i    = 8'h00;
  logic                    body_start_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i  = 1'b0;
  logic [7:0]              out_byte_o;
  logic [1:0]              status_o;
  logic [CountOutBits-1:0] consumed_count_o;

  chunk_decode_scoreboard sb = new();

  int         idle_pct   = 0;
  int         stall_pct  = 0;
  bit         hold_req   = 1'b0;
  int         hold_left  = 0;
  int         input_held = 0;
  logic [7:0] body_bytes[$];

  http_chunked_body_decoder_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .body_start_i    (body_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .status_o        (status_o),
    .consumed_count_o(consumed_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) input_held++;
      if (out_valid_o && !out_stall_i) begin
        sb.compare_output(out_byte_o, status_o, consumed_count_o, $time);
      end
    end
  end

  initial begin
    #5ms;
    $display("http_chunked_body_decoder_core: mismatch");
    $finish;
  end

  // Offer one byte and hold it until the transfer; entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_byte_i    <= b;
    body_start_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    sb.decode_byte(b, start);
    @(negedge clk_i);
  endtask

  task automatic send_body(input logic start);
    foreach (body_bytes[i]) send_byte(body_bytes[i], start && (i == 0));
    body_bytes.delete();
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) body_bytes.push_back(s[i]);
  endtask

  task automatic put_noise(input int n);
    repeat (n) body_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic put_size_line(input int unsigned n);
    logic [7:0]  digs[$];
    int unsigned v;
    int unsigned d;
    v = n;
    repeat ($urandom_range(2)) body_bytes.push_back($urandom_range(1) ? ChrSpace : ChrTab);
    repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0) body_bytes.push_back("0");
    if (v == 0) digs.push_front("0");
    while (v != 0) begin
      d = v % 16;
      if (d < 10) digs.push_front(8'(8'h30 + d));
      else digs.push_front(8'(($urandom_range(1) ? 8'h61 : 8'h41) + d - 10));
      v = v / 16;
    end
    foreach (digs[i]) body_bytes.push_back(digs[i]);
    case ($urandom_range(5))
      0: begin
        body_bytes.push_back(";");
        repeat ($urandom_range(1, 6)) body_bytes.push_back(8'($urandom_range(8'h21, 8'h7e)));
      end
      1: begin
        body_bytes.push_back($urandom_range(1) ? ChrSpace : ChrTab);
        repeat ($urandom_range(3)) body_bytes.push_back(8'($urandom_range(8'h21, 8'h7e)));
      end
      2: put_str("\rx");
      default: ;
    endcase
    put_str("\r\n");
  endtask

  task automatic put_chunk(input int unsigned len);
    put_size_line(len);
    put_noise(len);
    if ($urandom_range(15) == 0) put_noise(1);
    else put_str("\r\n");
  endtask

  task automatic put_body();
    int pos;
    int mode;
    mode = $urandom_range(99);
    if (mode < 6) begin
      // size with too many digits
      repeat ($urandom_range(9, 11)) body_bytes.push_back($urandom_range(1) ? "f" : "9");
      put_str("\r\n");
    end else if (mode < 11) begin
      put_noise($urandom_range(1, 20));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        put_chunk($urandom_range(9) == 0 ? $urandom_range(13, 40) : $urandom_range(1, 12));
      end
      put_size_line(0);
      if ($urandom_range(15) == 0) put_noise(2);
      else put_str("\r\n");
      if (mode >= 90) begin
        pos = $urandom_range(body_bytes.size() - 1);
        body_bytes[pos] = 8'($urandom_range(255));
      end else if (mode >= 84) begin
        pos = $urandom_range(body_bytes.size() - 1);
        while (body_bytes.size() > pos + 1) void'(body_bytes.pop_back());
      end
      // trailing bytes after completion are ignored by the block
      if ($urandom_range(3) == 0) put_noise($urandom_range(1, 3));
    end
  endtask

  initial begin
    int goal;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // decode straight from reset: blanks, extension, data extremes, completion, ignored tail
    put_str(" \t2;x\r\n");
    body_bytes.push_back(8'h00);
    body_bytes.push_back(8'hff);
    put_str("\r\n0\r\n\r\nZ");
    send_body(1'b0);
    put_str("G\r\n");           // size line with no digits
    send_body(1'b1);
    put_str("aBcDeF012");       // size overflows on the ninth digit
    send_body(1'b1);
    put_str("1\r\rx\r\nQX");    // lone CR in the size line, then no CR LF after data
    send_body(1'b1);
    put_str("0\r\nX");          // zero line not followed by CR LF
    send_body(1'b1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_req = 1'b1; end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      goal = sb.live_bytes + 175;
      while (sb.live_bytes < goal) begin
        put_body();
        send_body(1'b1);
      end
    end

    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (sb.awaiting() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Decoded %0d live bytes over %0d bodies: %0d data, %0d complete, %0d malformed.",
             sb.live_bytes, sb.bodies, sb.data_seen, sb.done_seen, sb.bad_seen);
    $display("Input held off by the block for %0d cycles.", input_held);
    if (sb.errors == 0) begin
      $display("http_chunked_body_decoder_core: match");
    end else begin
      $display("http_chunked_body_decoder_core: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
src/hcbd_pkg.sv
src/hcbd_step.sv
src/http_chunked_body_decoder_core.sv
tb/sv/hcbd_tb_pkg.sv
tb/sv/tb_http_chunked_body_decoder_core.sv
